### hdl/bbh_pkg.sv
package bbh_pkg;

	localparam int NGRAM_LEN   = 2;
	localparam int COUNT_BITS  = 32;
	localparam int TOTAL_BITS  = 40;
	localparam int QUERY_BITS  = 32;
	localparam int KEY_BITS    = 16;
	localparam int BYTE_BITS   = 8;
	localparam int FILL_BITS   = 2;
	localparam int MEM_DEPTH   = 2 ** KEY_BITS;

	localparam logic [BYTE_BITS-1:0] BYTE_NEWLINE = 8'h0A;
	localparam logic [BYTE_BITS-1:0] BYTE_CR      = 8'h0D;
	localparam logic [BYTE_BITS-1:0] BYTE_BF      = 8'hBF;

	localparam logic MODE_TEXT  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};
	localparam logic [FILL_BITS-1:0]  FILL_MAX  = {FILL_BITS{1'b1}};

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE
	} bbh_state_t;

	typedef struct packed {
		logic clear_wr;
		logic accept;
		logic update;
	} bbh_cmd_t;

	typedef struct packed {
		logic clear_last;
	} bbh_status_t;

	function automatic logic byte_forbidden(input logic [BYTE_BITS-1:0] b);
		logic r;
		case (b)
			8'h20, 8'h5E, 8'h5B, 8'h5D, 8'h2C, 8'h2E, 8'h2D, 8'h3B,
			8'h3A, 8'h3F, 8'h21, 8'h5F, 8'h27, 8'h2A, 8'h28, 8'h29,
			8'h40, 8'h2B, 8'h24, 8'h22, 8'hC2, 8'hAB, 8'hBB: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic [BYTE_BITS-1:0] to_lower(input logic [BYTE_BITS-1:0] b);
		logic [BYTE_BITS-1:0] r;
		r = b;
		if (b >= 8'h41 && b <= 8'h5A) begin
			r = b + 8'h20;
		end
		return r;
	endfunction

endpackage

### hdl/bbh_req_if.sv
interface bbh_req_if;
	logic                           valid;
	logic                           ready;
	logic                           mode;
	logic [bbh_pkg::BYTE_BITS-1:0]  byte_value;
	logic [bbh_pkg::KEY_BITS-1:0]   query_key;

	modport source (output valid, mode, byte_value, query_key, input ready);
	modport sink (input valid, mode, byte_value, query_key, output ready);
endinterface

### hdl/bbh_rsp_if.sv
interface bbh_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [bbh_pkg::QUERY_BITS-1:0] query_count;
	logic                           counted;
	logic [bbh_pkg::TOTAL_BITS-1:0] total_count;

	modport source (output valid, query_count, counted, total_count, input ready);
	modport sink (input valid, query_count, counted, total_count, output ready);
endinterface

### hdl/bbh_ctrl.sv
module bbh_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  bbh_pkg::bbh_status_t status,
	output bbh_pkg::bbh_cmd_t    cmd
);

	bbh_pkg::bbh_state_t state_q, state_d;
	logic                out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbh_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '0;
		case (state_q)
			bbh_pkg::ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (status.clear_last) begin
					state_d = bbh_pkg::ST_IDLE;
				end
			end
			bbh_pkg::ST_IDLE: begin
				req_ready  = !out_valid_q || rsp_ready;
				cmd.accept = req_valid && req_ready;
				if (cmd.accept) begin
					state_d = bbh_pkg::ST_UPDATE;
				end
			end
			bbh_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = bbh_pkg::ST_IDLE;
			end
			default: begin
				state_d = bbh_pkg::ST_IDLE;
			end
		endcase
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.update) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bbh_pkg::ST_CLEAR |-> !req_ready)
		else $error("input taken during clear pass");
	a_accept_then_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == bbh_pkg::ST_UPDATE && !out_valid_q)
		else $error("accepted item not followed by update with free result slot");
	a_update_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> out_valid_q)
		else $error("update did not produce a result");

endmodule

### hdl/bbh_datapath.sv
module bbh_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bbh_pkg::bbh_cmd_t              cmd,
	output bbh_pkg::bbh_status_t           status,
	input  logic                           mode,
	input  logic [bbh_pkg::BYTE_BITS-1:0]  byte_value,
	input  logic [bbh_pkg::KEY_BITS-1:0]   query_key,
	output logic [bbh_pkg::QUERY_BITS-1:0] query_count,
	output logic                           counted,
	output logic [bbh_pkg::TOTAL_BITS-1:0] total_count
);

	localparam int BW = bbh_pkg::BYTE_BITS;
	localparam int KW = bbh_pkg::KEY_BITS;
	localparam int CW = bbh_pkg::COUNT_BITS;

	logic [CW-1:0] mem [bbh_pkg::MEM_DEPTH];

	logic [BW-1:0]                  win_q;
	logic [bbh_pkg::FILL_BITS-1:0]  fill_q;
	logic [bbh_pkg::TOTAL_BITS-1:0] total_q;
	logic [KW-1:0]                  clr_addr_q;

	logic          mode_s1;
	logic          cnt_s1;
	logic [KW-1:0] key_s1;
	logic [CW-1:0] rd_data_q;

	logic [bbh_pkg::QUERY_BITS-1:0] qc_q;
	logic                           counted_q;

	logic [BW-1:0] low_b;
	logic          is_text, is_newline, is_kept, complete, bad, do_cnt;
	logic [KW-1:0] gram_key, rd_addr, wr_addr;
	logic [CW-1:0] wr_data;
	logic          wr_en;

	always_comb begin
		low_b      = bbh_pkg::to_lower(byte_value);
		is_text    = mode == bbh_pkg::MODE_TEXT;
		is_newline = is_text && byte_value == bbh_pkg::BYTE_NEWLINE;
		is_kept    = is_text && !is_newline && byte_value != bbh_pkg::BYTE_CR &&
			byte_value != bbh_pkg::BYTE_BF;
		if (bbh_pkg::NGRAM_LEN >= 2) begin
			complete = fill_q != '0;
			gram_key = KW'({win_q, low_b});
			bad      = bbh_pkg::byte_forbidden(win_q) || bbh_pkg::byte_forbidden(low_b);
		end else begin
			complete = 1'b1;
			gram_key = KW'(low_b);
			bad      = bbh_pkg::byte_forbidden(low_b);
		end
		do_cnt  = is_kept && complete && !bad;
		rd_addr = is_text ? gram_key : query_key;
		wr_en   = cmd.clear_wr || (cmd.update && cnt_s1);
		wr_addr = cmd.clear_wr ? clr_addr_q : key_s1;
		if (cmd.clear_wr) begin
			wr_data = '0;
		end else if (rd_data_q == bbh_pkg::COUNT_MAX) begin
			wr_data = rd_data_q;
		end else begin
			wr_data = rd_data_q + CW'(1);
		end
	end

	// counter memory: one read at accept, one write at update or clear
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.accept) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_s1 <= mode;
			cnt_s1  <= do_cnt;
			key_s1  <= gram_key;
		end
		if (cmd.update) begin
			qc_q      <= (mode_s1 == bbh_pkg::MODE_QUERY) ?
				bbh_pkg::QUERY_BITS'(rd_data_q) : '0;
			counted_q <= cnt_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q      <= '0;
			fill_q     <= '0;
			total_q    <= '0;
			clr_addr_q <= '0;
		end else begin
			if (cmd.clear_wr) begin
				clr_addr_q <= clr_addr_q + KW'(1);
			end
			if (cmd.accept && is_newline) begin
				win_q  <= '0;
				fill_q <= '0;
			end else if (cmd.accept && is_kept) begin
				win_q <= low_b;
				if (fill_q != bbh_pkg::FILL_MAX) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (cmd.update && cnt_s1 && total_q != bbh_pkg::TOTAL_MAX) begin
				total_q <= total_q + 1'b1;
			end
		end
	end

	assign status.clear_last = clr_addr_q == {KW{1'b1}};
	assign query_count       = qc_q;
	assign counted           = counted_q;
	assign total_count       = total_q;

	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.update |=> $stable(total_q))
		else $error("total moved outside an update");
	a_query_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && mode_s1 == bbh_pkg::MODE_QUERY |-> !cnt_s1)
		else $error("query marked as counted");
	a_no_write_while_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> !wr_en)
		else $error("memory write collides with read");

endmodule

### hdl/byte_bigram_histogram_core.sv
// channel   dir  handshake      payload
// req       in   valid/ready    mode, byte_value, query_key
// rsp       out  valid/ready    query_count, counted, total_count
//
// each item reads the counter memory at accept, then writes a counted bigram's counter back at update
// reset starts a clear pass over all 65536 counters, one counter per cycle; req.ready stays low
// the result register lets the next item enter in the cycle the result is taken
// a stalled rsp holds its result and blocks new items until the transfer
module byte_bigram_histogram_core (
	input logic      clk,
	input logic      arst_n,
	bbh_req_if.sink  req,
	bbh_rsp_if.source rsp
);

	bbh_pkg::bbh_cmd_t    cmd;
	bbh_pkg::bbh_status_t status;

	// controller: clear pass, accept, update sequencing and result valid
	bbh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath: line window, counter memory, running total, result register
	bbh_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.mode        (req.mode),
		.byte_value  (req.byte_value),
		.query_key   (req.query_key),
		.query_count (rsp.query_count),
		.counted     (rsp.counted),
		.total_count (rsp.total_count)
	);

endmodule
